// ----- sv/sorted_record_table_defines.svh -----
// ----------------------------------------------------------------------------
// sorted_record_table_defines
// assertion macros shared by the record table rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_RECORD_TABLE_DEFINES_SVH
`define SORTED_RECORD_TABLE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SRT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/srt_pkg.sv -----
// ----------------------------------------------------------------------------
// srt_pkg
// types, codes and constants of the sorted record table
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int NAME_BYTES_DEF = 8;
    localparam int TYPE_BYTES_DEF = 8;

    localparam int KEY_W      = 64;
    localparam int QTY_W      = 16;
    localparam int PRI_W      = 3;
    localparam int LIST_LIMIT = 16;

    localparam logic [PRI_W-1:0] PRI_MIN     = 3'd1;
    localparam logic [PRI_W-1:0] PRI_MAX     = 3'd5;
    localparam logic [PRI_W-1:0] PRI_DEFAULT = 3'd3;

    localparam logic [2:0] F_INSERT  = 3'd0;
    localparam logic [2:0] F_REMOVE  = 3'd1;
    localparam logic [2:0] F_LOOKUP  = 3'd2;
    localparam logic [2:0] F_SORT    = 3'd3;
    localparam logic [2:0] F_BSEARCH = 3'd4;
    localparam logic [2:0] F_LIST    = 3'd5;

    localparam logic [1:0] CRIT_NAME = 2'd0;
    localparam logic [1:0] CRIT_TYPE = 2'd1;
    localparam logic [1:0] CRIT_PRI  = 2'd2;
    localparam logic [1:0] CRIT_BAD  = 2'd3;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_BADCRIT  = 3'd4,
        ST_SINGLE   = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LS_RD,
        S_LS_CHK,
        S_RM,
        S_RM_WR,
        S_SO_INIT,
        S_SO_KEY,
        S_SO_CMP,
        S_SO_PUT,
        S_SO_NEXT,
        S_BS_PROBE,
        S_BS_CHK,
        S_LI_RD,
        S_LI_EM
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] name;
        logic [KEY_W-1:0] kind;
        logic [QTY_W-1:0] qty;
        logic [PRI_W-1:0] pri;
    } rec_t;

    typedef struct packed {
        logic shift;
        logic eq;
        logic lt;
    } cmp_res_t;

endpackage

// ----- sv/srt_ram.sv -----
// ----------------------------------------------------------------------------
// srt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/srt_cmp.sv -----
// ----------------------------------------------------------------------------
// srt_cmp
// shared key compare unit for sort, scan and binary search
// ----------------------------------------------------------------------------
module srt_cmp
    import srt_pkg::*;
(
    input  rec_t       a,
    input  rec_t       b,
    input  logic [1:0] crit,
    output cmp_res_t   res
);

    always_comb
    begin
        case (crit)
            CRIT_NAME: res.shift = a.name > b.name;
            CRIT_TYPE: res.shift = a.kind > b.kind;
            default:   res.shift = a.pri < b.pri;
        endcase
        res.eq = a.name == b.name;
        res.lt = a.name < b.name;
    end

endmodule

// ----- sv/sorted_record_table.sv -----
// insert: result in the cycle after start, busy stays low.
// remove and linear lookup: a read and a check state per record scanned; remove adds a read and a write per move.
// sort: a compare state per key compare plus key read and next states per record,
// set by the single ram read port shared by the compare unit; binary lookup adds a probe and a check state per probe.
// list: a read and an emit state per record, one result each. results cannot be stalled.
// reset clears the entry count and the name-order flag; table contents stay undefined.
// ----------------------------------------------------------------------------
// sorted_record_table
// record table with insert, remove, lookups, insertion sort and list
// ----------------------------------------------------------------------------
`include "sorted_record_table_defines.svh"

module sorted_record_table
    import srt_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF,
    parameter int TYPE_BYTES = TYPE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [63:0] name_key,
    input  logic [63:0] type_key,
    input  logic [15:0] quantity_in,
    input  logic [2:0]  priority_in,
    input  logic [1:0]  criterion,
    output logic        valid,
    output logic [2:0]  status,
    output logic [63:0] rec_name,
    output logic [63:0] rec_type,
    output logic [15:0] rec_quantity,
    output logic [2:0]  rec_priority,
    output logic [3:0]  position,
    output logic [7:0]  comparisons,
    output logic [4:0]  entry_count,
    output logic        name_ordered,
    output logic        last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [KEY_W-1:0] NAME_MASK = (NAME_BYTES >= 8) ? {KEY_W{1'b1}} :
        ((KEY_W'(1) << (8 * NAME_BYTES)) - KEY_W'(1));
    localparam logic [KEY_W-1:0] TYPE_MASK = (TYPE_BYTES >= 8) ? {KEY_W{1'b1}} :
        ((KEY_W'(1) << (8 * TYPE_BYTES)) - KEY_W'(1));

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            sorted_reg, sorted_next;
    logic [2:0]      op_reg, op_next;
    logic [1:0]      crit_reg, crit_next;
    logic [KEY_W-1:0] name_reg, name_next;
    rec_t            key_reg, key_next;
    rec_t            hold_reg, hold_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [AW-1:0]   j_reg, j_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   lo_reg, lo_next;
    logic [CW-1:0]   hp_reg, hp_next;
    logic [CW-1:0]   mid_reg, mid_next;
    logic [7:0]      cmp_reg, cmp_next;
    logic [6:0]      lim_reg, lim_next;

    logic            valid_reg;
    status_t         status_reg;
    rec_t            out_rec_reg;
    logic [3:0]      pos_reg;
    logic [7:0]      out_cmp_reg;
    logic            last_reg;

    logic            emit;
    status_t         e_status;
    logic            e_has;
    rec_t            e_rec;
    logic [CW-1:0]   e_pos;
    logic [7:0]      e_cmp;
    logic            e_last;
    logic            sort_fin;

    logic            we;
    logic [AW-1:0]   waddr;
    rec_t            wdata;
    logic [AW-1:0]   raddr;
    rec_t            rdata;
    rec_t            cmp_b;
    cmp_res_t        cres;

    rec_t            ins_rec;
    logic [CW-1:0]   i_inc;
    logic [CW-1:0]   idx_inc;
    logic [7:0]      cmp_inc;
    logic [CW:0]     mid_sum;
    logic [CW-1:0]   mid_calc;
    logic [6:0]      list_n;

    srt_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    srt_cmp u_cmp (
        .a    (rdata),
        .b    (cmp_b),
        .crit (crit_reg),
        .res  (cres)
    );

    always_comb
    begin
        ins_rec.name = name_key & NAME_MASK;
        ins_rec.kind = type_key & TYPE_MASK;
        ins_rec.qty  = quantity_in;
        ins_rec.pri  = (priority_in < PRI_MIN || priority_in > PRI_MAX) ? PRI_DEFAULT
                                                                      : priority_in;
        i_inc    = i_reg + CW'(1);
        idx_inc  = idx_reg + CW'(1);
        cmp_inc  = (cmp_reg == 8'hFF) ? cmp_reg : cmp_reg + 8'd1;
        mid_sum  = {1'b0, lo_reg} + {1'b0, hp_reg} - (CW + 1)'(1);
        mid_calc = mid_sum[CW:1];
        list_n   = (7'(count_reg) > 7'(LIST_LIMIT)) ? 7'(LIST_LIMIT) : 7'(count_reg);
        // sorting compares against the held key record, searching against the name
        if (state_reg == S_SO_CMP)
        begin
            cmp_b = key_reg;
        end
        else
        begin
            cmp_b      = '0;
            cmp_b.name = name_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        sorted_next = sorted_reg;
        op_next     = op_reg;
        crit_next   = crit_reg;
        name_next   = name_reg;
        key_next    = key_reg;
        hold_next   = hold_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        idx_next    = idx_reg;
        lo_next     = lo_reg;
        hp_next     = hp_reg;
        mid_next    = mid_reg;
        cmp_next    = cmp_reg;
        lim_next    = lim_reg;
        emit        = 1'b0;
        e_status    = ST_OK;
        e_has       = 1'b0;
        e_rec       = '0;
        e_pos       = '0;
        e_cmp       = '0;
        e_last      = 1'b1;
        sort_fin    = 1'b0;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        raddr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = func;
                    name_next = name_key;
                    crit_next = (func == F_BSEARCH) ? CRIT_NAME : criterion;
                    i_next    = '0;
                    idx_next  = '0;
                    cmp_next  = '0;
                    lim_next  = list_n;
                    case (func)
                        F_INSERT:
                        begin
                            emit = 1'b1;
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                e_status = ST_FULL;
                            end
                            else
                            begin
                                we          = 1'b1;
                                waddr       = count_reg[AW-1:0];
                                wdata       = ins_rec;
                                count_next  = count_reg + CW'(1);
                                sorted_next = 1'b0;
                                e_has       = 1'b1;
                                e_rec       = ins_rec;
                                e_pos       = count_reg;
                            end
                        end
                        F_REMOVE, F_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                emit     = 1'b1;
                                e_status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_LS_RD;
                            end
                        end
                        F_SORT:
                        begin
                            if (count_reg == '0)
                            begin
                                emit     = 1'b1;
                                e_status = ST_EMPTY;
                            end
                            else if (count_reg == CW'(1))
                            begin
                                emit     = 1'b1;
                                e_status = ST_SINGLE;
                            end
                            else if (criterion == CRIT_BAD)
                            begin
                                emit     = 1'b1;
                                e_status = ST_BADCRIT;
                            end
                            else
                            begin
                                state_next = S_SO_INIT;
                            end
                        end
                        F_BSEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                emit     = 1'b1;
                                e_status = ST_EMPTY;
                            end
                            else if (sorted_reg)
                            begin
                                lo_next    = '0;
                                hp_next    = count_reg;
                                state_next = S_BS_PROBE;
                            end
                            else
                            begin
                                state_next = S_SO_INIT;
                            end
                        end
                        F_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                emit     = 1'b1;
                                e_status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_LI_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_LS_RD:
            begin
                raddr      = idx_reg[AW-1:0];
                state_next = S_LS_CHK;
            end

            S_LS_CHK:
            begin
                if (cres.eq)
                begin
                    if (op_reg == F_LOOKUP)
                    begin
                        emit       = 1'b1;
                        e_has      = 1'b1;
                        e_rec      = rdata;
                        e_pos      = idx_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        hold_next  = rdata;
                        i_next     = idx_reg;
                        state_next = S_RM;
                    end
                end
                else if (idx_inc == count_reg)
                begin
                    emit       = 1'b1;
                    e_status   = ST_NOTFOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_LS_RD;
                end
            end

            S_RM:
            begin
                if (i_inc < count_reg)
                begin
                    raddr      = i_inc[AW-1:0];
                    state_next = S_RM_WR;
                end
                else
                begin
                    count_next  = count_reg - CW'(1);
                    sorted_next = 1'b0;
                    emit        = 1'b1;
                    e_has       = 1'b1;
                    e_rec       = hold_reg;
                    e_pos       = idx_reg;
                    state_next  = S_IDLE;
                end
            end

            S_RM_WR:
            begin
                we         = 1'b1;
                waddr      = i_reg[AW-1:0];
                wdata      = rdata;
                i_next     = i_inc;
                state_next = S_RM;
            end

            S_SO_INIT:
            begin
                i_next = CW'(1);
                if (CW'(1) < count_reg)
                begin
                    raddr      = AW'(1);
                    state_next = S_SO_KEY;
                end
                else
                begin
                    sort_fin = 1'b1;
                end
            end

            S_SO_KEY:
            begin
                key_next   = rdata;
                j_next     = i_reg[AW-1:0];
                raddr      = i_reg[AW-1:0] - AW'(1);
                state_next = S_SO_CMP;
            end

            S_SO_CMP:
            begin
                cmp_next = cmp_inc;
                we       = 1'b1;
                waddr    = j_reg;
                if (cres.shift)
                begin
                    wdata  = rdata;
                    j_next = j_reg - AW'(1);
                    if (j_reg == AW'(1))
                    begin
                        state_next = S_SO_PUT;
                    end
                    else
                    begin
                        // fetch the next earlier record while this one moves up
                        raddr = j_reg - AW'(1) - AW'(1);
                    end
                end
                else
                begin
                    wdata      = key_reg;
                    state_next = S_SO_NEXT;
                end
            end

            S_SO_PUT:
            begin
                we         = 1'b1;
                waddr      = j_reg;
                wdata      = key_reg;
                state_next = S_SO_NEXT;
            end

            S_SO_NEXT:
            begin
                if (i_inc < count_reg)
                begin
                    i_next     = i_inc;
                    raddr      = i_inc[AW-1:0];
                    state_next = S_SO_KEY;
                end
                else
                begin
                    sort_fin = 1'b1;
                end
            end

            S_BS_PROBE:
            begin
                if (lo_reg < hp_reg)
                begin
                    mid_next   = mid_calc;
                    raddr      = mid_calc[AW-1:0];
                    cmp_next   = cmp_inc;
                    state_next = S_BS_CHK;
                end
                else
                begin
                    emit       = 1'b1;
                    e_status   = ST_NOTFOUND;
                    e_cmp      = cmp_reg;
                    state_next = S_IDLE;
                end
            end

            S_BS_CHK:
            begin
                if (cres.eq)
                begin
                    emit       = 1'b1;
                    e_has      = 1'b1;
                    e_rec      = rdata;
                    e_pos      = mid_reg;
                    e_cmp      = cmp_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    if (cres.lt)
                    begin
                        lo_next = mid_reg + CW'(1);
                    end
                    else
                    begin
                        hp_next = mid_reg;
                    end
                    state_next = S_BS_PROBE;
                end
            end

            S_LI_RD:
            begin
                raddr      = i_reg[AW-1:0];
                state_next = S_LI_EM;
            end

            S_LI_EM:
            begin
                emit   = 1'b1;
                e_has  = 1'b1;
                e_rec  = rdata;
                e_pos  = i_reg;
                e_last = 7'(i_inc) == lim_reg;
                if (7'(i_inc) == lim_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_LI_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // end of a sort pass: report it, or go on to the binary search
        if (sort_fin)
        begin
            if (op_reg == F_SORT)
            begin
                emit        = 1'b1;
                e_cmp       = cmp_reg;
                sorted_next = crit_reg == CRIT_NAME;
                state_next  = S_IDLE;
            end
            else
            begin
                sorted_next = 1'b1;
                cmp_next    = '0;
                lo_next     = '0;
                hp_next     = count_reg;
                state_next  = S_BS_PROBE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            sorted_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sorted_reg <= sorted_next;
            valid_reg  <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        crit_reg <= crit_next;
        name_reg <= name_next;
        key_reg  <= key_next;
        hold_reg <= hold_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        idx_reg  <= idx_next;
        lo_reg   <= lo_next;
        hp_reg   <= hp_next;
        mid_reg  <= mid_next;
        cmp_reg  <= cmp_next;
        lim_reg  <= lim_next;
        if (emit)
        begin
            status_reg  <= e_status;
            out_rec_reg <= e_has ? e_rec : '0;
            pos_reg     <= e_has ? 4'(e_pos) : 4'd0;
            out_cmp_reg <= e_cmp;
            last_reg    <= e_last;
        end
    end

    assign busy         = state_reg != S_IDLE;
    assign valid        = valid_reg;
    assign status       = status_reg;
    assign rec_name     = out_rec_reg.name;
    assign rec_type     = out_rec_reg.kind;
    assign rec_quantity = out_rec_reg.qty;
    assign rec_priority = out_rec_reg.pri;
    assign position     = pos_reg;
    assign comparisons  = out_cmp_reg;
    assign entry_count  = 5'(count_reg);
    assign name_ordered = sorted_reg;
    assign last         = last_reg;

    `SRT_ASSERT_SAME(a_count_cap, 1'b1, count_reg <= CW'(CAPACITY), "entry count above capacity")
    `SRT_ASSERT_SAME(a_list_busy, valid && !last, busy, "list run stopped before its last item")
    `SRT_ASSERT_NEXT(a_insert_one, start && !busy && func == F_INSERT, valid && !busy,
                     "insert did not answer in one cycle")
    `SRT_ASSERT_SAME(a_err_single, valid && status != ST_OK, last, "error item not marked last")

endmodule
